>>> hw/rtl/txclt_pkg.sv
`timescale 1ns / 1ps
// txclt_pkg: shared sizes, mode codes and request/result types for the
// tx completion latency tracker. No dependencies.
package txclt_pkg;

	localparam int PENDING_SLOTS   = 64;
	localparam int LATENCY_SAMPLES = 32;

	localparam int MODE_W = 3;
	localparam int SEQ_W  = 12;
	localparam int TIME_W = 64;
	localparam int CNT_W  = 7;
	localparam int LAT_W  = 25;

	localparam int SLOT_W     = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
	localparam int RING_W     = (LATENCY_SAMPLES > 1) ? $clog2(LATENCY_SAMPLES) : 1;
	localparam int SCNT_W     = $clog2(LATENCY_SAMPLES + 1);
	localparam int SUM_W      = LAT_W + RING_W;
	localparam int DIV_STEP_W = $clog2(SUM_W);

	localparam logic [TIME_W-1:0] LAT_MAX_US = TIME_W'(30000000);
	localparam logic [CNT_W-1:0]  COUNT_MAX  = {CNT_W{1'b1}};

	localparam logic [MODE_W-1:0] MODE_SUBMIT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_CANCEL = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DONE   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [SEQ_W-1:0]  seq;
		logic [TIME_W-1:0] now_us;
	} item_t;

	// first member lands in the top bits, so outstanding sits lowest
	typedef struct packed {
		logic [LAT_W-1:0] avg_latency_us;
		logic             avg_valid;
		logic [LAT_W-1:0] sample_us;
		logic             recorded;
		logic             matched;
		logic [CNT_W-1:0] outstanding;
	} res_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  seq;
		logic              hol;
		logic [TIME_W-1:0] submit_us;
	} slot_t;

	localparam int RES_W        = $bits(res_t);
	localparam int IN_DATA_W    = SEQ_W + TIME_W;
	localparam int IN_TDATA_W   = ((IN_DATA_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W  = ((RES_W + 7) / 8) * 8;

endpackage

>>> hw/rtl/txclt_ram.sv
`timescale 1ns / 1ps
// txclt_ram: generic single write, single read memory with registered read.
// No dependencies.
module txclt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/txclt_div.sv
`timescale 1ns / 1ps
// txclt_div: restoring divider, one quotient bit per cycle, for the mean.
// Depends on txclt_pkg.
module txclt_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [txclt_pkg::SUM_W-1:0]  dividend,
	input  logic [txclt_pkg::SCNT_W-1:0] divisor,
	output logic                        done,
	output logic [txclt_pkg::SUM_W-1:0]  quotient
);
	import txclt_pkg::*;

	localparam logic [DIV_STEP_W-1:0] STEP_LAST = DIV_STEP_W'(SUM_W - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic [SCNT_W-1:0]     rem_q;
	logic [SUM_W-1:0]      quot_q;
	logic [SCNT_W-1:0]     div_q;
	logic [SCNT_W:0]       rem_sh;
	logic [SCNT_W:0]       rem_nxt;
	logic                  ge;

	assign rem_sh  = {rem_q, quot_q[SUM_W-1]};
	assign ge      = rem_sh >= {1'b0, div_q};
	assign rem_nxt = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			div_q  <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top bit is always clear
			rem_q  <= rem_nxt[SCNT_W-1:0];
			quot_q <= {quot_q[SUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

>>> hw/rtl/txclt_core.sv
`timescale 1ns / 1ps
// txclt_core: request sequencer with slot table and sample ring memories.
// Depends on txclt_pkg, txclt_ram and txclt_div.
module txclt_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  txclt_pkg::item_t item,
	output logic             res_valid,
	input  logic             res_ready,
	output txclt_pkg::res_t  res
);
	import txclt_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_LAT   = 3'd2;
	localparam logic [2:0] ST_SUM   = 3'd3;
	localparam logic [2:0] ST_DIVGO = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_RES   = 3'd6;

	logic [2:0]               state_q;
	logic [MODE_W-1:0]        mode_q;
	logic [SEQ_W-1:0]         seq_q;
	logic [TIME_W-1:0]        now_q;
	logic [PENDING_SLOTS-1:0] used_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [TIME_W-1:0]        last_q;
	logic [RING_W-1:0]        pos_q;
	logic [SCNT_W-1:0]        scnt_q;
	logic [SCNT_W-1:0]        rd_idx_q;
	logic [SUM_W-1:0]         acc_q;
	logic [TIME_W-1:0]        dt_q;
	res_t                     res_q;

	logic              accept;
	logic [SLOT_W-1:0] idx;
	slot_t             slot_rd;
	slot_t             slot_wr;
	logic              slot_we;
	logic              slot_used;
	logic              hit;
	logic [CNT_W-1:0]  cnt_inc;
	logic [CNT_W-1:0]  cnt_dec;
	logic [TIME_W-1:0] base;
	logic [TIME_W:0]   diff;
	logic              dt_ok;
	logic              store_ok;
	logic [RING_W-1:0] pos_nxt;
	logic              ring_we;
	logic              ring_re;
	logic [RING_W-1:0] ring_raddr;
	logic [LAT_W-1:0]  ring_rd;
	logic              div_start;
	logic              div_done;
	logic [SUM_W-1:0]  div_quot;

	assign accept     = item_valid && item_ready;
	assign item_ready = state_q == ST_IDLE;
	assign res_valid  = state_q == ST_RES;
	assign res        = res_q;

	assign idx       = seq_q[SLOT_W-1:0];
	assign slot_used = used_q[idx];
	assign hit       = slot_used && (slot_rd.seq == seq_q);
	assign cnt_inc   = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign cnt_dec   = (cnt_q == '0) ? cnt_q : cnt_q - 1'b1;

	// head-of-line frames measure from submit, others from the last completion
	assign base     = slot_rd.hol ? slot_rd.submit_us : last_q;
	assign diff     = {1'b0, now_q} - {1'b0, base};
	assign dt_ok    = !diff[TIME_W] && (slot_rd.hol || (last_q != '0));
	assign store_ok = (dt_q != '0) && (dt_q <= LAT_MAX_US);
	assign pos_nxt  = (pos_q == RING_W'(LATENCY_SAMPLES - 1)) ? '0 : pos_q + 1'b1;

	assign slot_we           = (state_q == ST_EXEC) && (mode_q == MODE_SUBMIT);
	assign slot_wr.seq       = seq_q;
	assign slot_wr.hol       = !slot_used && (cnt_q == '0);
	assign slot_wr.submit_us = now_q;

	assign ring_we    = (state_q == ST_LAT) && store_ok;
	assign ring_re    = ((state_q == ST_EXEC) && (mode_q == MODE_READ) && (scnt_q != '0))
		|| ((state_q == ST_SUM) && (rd_idx_q != scnt_q));
	assign ring_raddr = (state_q == ST_SUM) ? rd_idx_q[RING_W-1:0] : '0;
	assign div_start  = state_q == ST_DIVGO;

	txclt_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(PENDING_SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(idx),
		.wdata(slot_wr),
		.re   (accept),
		.raddr(item.seq[SLOT_W-1:0]),
		.rdata(slot_rd)
	);

	txclt_ram #(
		.WIDTH(LAT_W),
		.DEPTH(LATENCY_SAMPLES)
	) u_ring_ram (
		.clk  (clk),
		.we   (ring_we),
		.waddr(pos_q),
		.wdata(dt_q[LAT_W-1:0]),
		.re   (ring_re),
		.raddr(ring_raddr),
		.rdata(ring_rd)
	);

	txclt_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(acc_q),
		.divisor (scnt_q),
		.done    (div_done),
		.quotient(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			used_q   <= '0;
			cnt_q    <= '0;
			last_q   <= '0;
			pos_q    <= '0;
			scnt_q   <= '0;
			rd_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (mode_q)
						MODE_SUBMIT: begin
							used_q[idx] <= 1'b1;
							if (!slot_used) begin
								cnt_q <= cnt_inc;
							end
							state_q <= ST_RES;
						end
						MODE_CANCEL, MODE_DONE: begin
							if (hit) begin
								used_q[idx] <= 1'b0;
								cnt_q       <= cnt_dec;
								if (mode_q == MODE_DONE) begin
									last_q <= now_q;
								end
							end
							state_q <= (hit && (mode_q == MODE_DONE)) ? ST_LAT : ST_RES;
						end
						MODE_READ: begin
							if (scnt_q != '0) begin
								rd_idx_q <= SCNT_W'(1);
							end
							state_q <= (scnt_q != '0) ? ST_SUM : ST_RES;
						end
						MODE_CLEAR: begin
							scnt_q  <= '0;
							pos_q   <= '0;
							state_q <= ST_RES;
						end
						default: begin
							state_q <= ST_RES;
						end
					endcase
				end
				ST_LAT: begin
					if (store_ok) begin
						pos_q <= pos_nxt;
						if (scnt_q != SCNT_W'(LATENCY_SAMPLES)) begin
							scnt_q <= scnt_q + 1'b1;
						end
					end
					state_q <= ST_RES;
				end
				ST_SUM: begin
					// one read in flight; the last sample lands once all are issued
					if (rd_idx_q != scnt_q) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end else begin
						state_q <= ST_DIVGO;
					end
				end
				ST_DIVGO: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= item.mode;
			seq_q  <= item.seq;
			now_q  <= item.now_us;
			// a fresh result carries only the current count
			res_q  <= res_t'({{(RES_W - CNT_W){1'b0}}, cnt_q});
		end
		if (state_q == ST_EXEC) begin
			acc_q <= '0;
			dt_q  <= dt_ok ? diff[TIME_W-1:0] : '0;
			if (mode_q == MODE_SUBMIT && !slot_used) begin
				res_q.outstanding <= cnt_inc;
			end
			if ((mode_q == MODE_CANCEL || mode_q == MODE_DONE) && hit) begin
				res_q.matched     <= 1'b1;
				res_q.outstanding <= cnt_dec;
			end
		end
		if (state_q == ST_LAT && store_ok) begin
			res_q.recorded  <= 1'b1;
			res_q.sample_us <= dt_q[LAT_W-1:0];
		end
		if (state_q == ST_SUM) begin
			acc_q <= acc_q + SUM_W'(ring_rd);
		end
		if (state_q == ST_DIV && div_done) begin
			res_q.avg_valid      <= 1'b1;
			res_q.avg_latency_us <= div_quot[LAT_W-1:0];
		end
	end

endmodule

>>> hw/rtl/tx_completion_latency_tracker_top.sv
`timescale 1ns / 1ps
// tx completion latency tracker: stream wrapper with the output register.
// Depends on txclt_pkg and txclt_core.
//
// Requests enter on the s_ group: tuser carries the mode (submit, cancel,
// done, read average, clear statistics), tdata the sequence number and the
// microsecond timestamp. Every request yields exactly one result on the m_
// group: in-flight count, match and sample flags, the stored latency sample
// and, for a read, the mean of the stored samples.
// One request is worked on at a time. On the way to the output register,
// submit, cancel, clear, a done without a match and a read with no stored
// samples pass only the execute state; a matched done also the latency store
// state, any other read the summing state (one sample ring read per cycle)
// and a divider that yields one quotient bit per cycle. s_tready rises
// again the cycle after the result is loaded, so a new request can be
// taken while the previous result still waits in the output register.
// If the receiver stalls, the result is held and the next result waits in the
// core, which then accepts nothing more.
// Reset clears the slot valid bits, counters, ring position and the last
// completion time at once; there is no clearing pass.
module tx_completion_latency_tracker_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [txclt_pkg::IN_TDATA_W-1:0]    s_tdata,  // seq, now_us, zero pad
	input  logic [txclt_pkg::MODE_W-1:0]        s_tuser,  // mode
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// outstanding, matched, recorded, sample_us, avg_valid, avg_latency_us, zero pad
	output logic [txclt_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import txclt_pkg::*;

	item_t item;
	res_t  core_res;
	logic  core_res_valid;
	logic  core_res_ready;
	logic  m_tvalid_q;
	res_t  m_res_q;

	assign item.mode   = s_tuser;
	assign item.seq    = s_tdata[SEQ_W-1:0];
	assign item.now_us = s_tdata[SEQ_W+TIME_W-1:SEQ_W];

	txclt_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(s_tvalid),
		.item_ready(s_tready),
		.item      (item),
		.res_valid (core_res_valid),
		.res_ready (core_res_ready),
		.res       (core_res)
	);

	assign core_res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (core_res_ready) begin
			m_tvalid_q <= core_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (core_res_ready && core_res_valid) begin
			m_res_q <= core_res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, m_res_q};

endmodule

>>> hw/rtl/txclt_checker.sv
`timescale 1ns / 1ps
// txclt_checker: port-level checks for the tracker top level, bound to it.
// Depends on txclt_pkg.
module txclt_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [txclt_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import txclt_pkg::*;

	res_t r;

	assign r = m_tdata[RES_W-1:0];

	// a stalled result holds its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one request at a time: no back-to-back acceptance
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	// a stored sample needs a matched completion and is nonzero
	a_rec: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r.recorded |-> r.matched && (r.sample_us != '0) && !r.avg_valid)
		else $error("sample flags inconsistent");

	// no sample value without the flag, and the count is bounded by the table
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (r.recorded || (r.sample_us == '0))
			&& (r.outstanding <= CNT_W'(PENDING_SLOTS)))
		else $error("result fields out of range");

endmodule

bind tx_completion_latency_tracker_top txclt_checker u_txclt_checker (.*);
